>>> design/psa_pkg.sv
// Shared types and constants of the purgeable segment allocator.
// Holds command, result and register codes, the micro-op set and the
// controller/datapath command and status structures. No dependencies.
package psa_pkg;

	localparam int MAX_BLOCKS = 32;
	localparam int IDX_W      = $clog2(MAX_BLOCKS);
	localparam int LINK_W     = 6;
	localparam int ADDR_W     = 24;
	localparam int OWNER_W    = 16;
	localparam int CMD_W      = 3;
	localparam int KIND_W     = 3;
	localparam int STAT_W     = 2;
	localparam int PURGE_W    = 2;
	localparam int CFG_IDX_W  = 1;
	localparam int STEP_W     = 7;

	localparam logic [LINK_W-1:0] NIL_LINK      = 6'd63;
	localparam logic [STEP_W-1:0] SET_STEP_LAST = STEP_W'(2 * MAX_BLOCKS + 2);
	localparam logic [ADDR_W-1:0] LIMIT_RESET   = '1;

	localparam logic [CMD_W-1:0] CMD_ALLOC     = 3'd0;
	localparam logic [CMD_W-1:0] CMD_FREE      = 3'd1;
	localparam logic [CMD_W-1:0] CMD_SET_PURGE = 3'd2;
	localparam logic [CMD_W-1:0] CMD_SET_LOCK  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_COMPACT   = 3'd4;

	localparam logic [KIND_W-1:0] KIND_GRANT  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_PURGED = 3'd1;
	localparam logic [KIND_W-1:0] KIND_MOVE   = 3'd2;
	localparam logic [KIND_W-1:0] KIND_DONE   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_ERROR  = 3'd4;

	localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
	localparam logic [STAT_W-1:0] ST_NO_MEMORY = 2'd1;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [STAT_W-1:0] ST_NO_PURGE  = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_BASE  = 1'b0;

	typedef enum logic [4:0] {
		OP_NOP, OP_LOAD, OP_CFG,
		OP_F_ROVER, OP_F_HEAD, OP_F_SCAN, OP_UNLINK, OP_RELSCAN,
		OP_C_HEAD, OP_C_SCAN,
		OP_AP_HEAD, OP_AP_SCAN,
		OP_A_RES, OP_A_PASS, OP_A_P2, OP_A_SET, OP_A_SCAN,
		OP_A_FIT1, OP_A_FIT2, OP_A_EV, OP_A_FAIL,
		OP_S_INIT, OP_S_SCAN, OP_FIN
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [KIND_W-1:0] fin_kind;
		logic [STAT_W-1:0] fin_status;
	} dp_cmd_t;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             flh_valid;
		logic             rover_zero;
		logic [1:0]       pass;
		logic             f_found;
		logic             f_end;
		logic             c_end;
		logic             c_evict;
		logic             ap_end;
		logic             ap_found;
		logic             a_stop;
		logic             a_fit;
		logic             ev_done;
		logic             s_done;
		logic             emit_ok;
	} dp_stat_t;

endpackage

>>> design/psa_dpath.sv
// Datapath of the purgeable segment allocator: descriptor pool, list
// pointers, walk registers and the result word register.
// Depends on psa_pkg; driven by psa_ctrl through dp_cmd_t.
module psa_dpath import psa_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dp_cmd_t              dcmd,
	output dp_stat_t             dstat,
	input  logic [CMD_W-1:0]     cmd,
	input  logic [OWNER_W-1:0]   owner_id,
	input  logic [ADDR_W-1:0]    request_size,
	input  logic [PURGE_W-1:0]   purge_level,
	input  logic                 lock_flag,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [ADDR_W-1:0]    cfg_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [KIND_W-1:0]    kind,
	output logic [OWNER_W-1:0]   result_owner,
	output logic [ADDR_W-1:0]    address,
	output logic [ADDR_W-1:0]    source_address,
	output logic [ADDR_W-1:0]    move_length,
	output logic [STAT_W-1:0]    status,
	output logic                 last
);

	function automatic logic is_valid(input logic [LINK_W-1:0] i);
		return i < LINK_W'(MAX_BLOCKS);
	endfunction

	function automatic logic [LINK_W-1:0] init_link(input int i);
		logic [LINK_W-1:0] v;
		if (i == 0)
			v = LINK_W'(1);
		else if (i == 1 || i + 1 >= MAX_BLOCKS)
			v = NIL_LINK;
		else
			v = LINK_W'(i + 1);
		return v;
	endfunction

	logic [ADDR_W-1:0]  base_q, limit_q;
	logic [ADDR_W-1:0]  start_q [MAX_BLOCKS];
	logic [ADDR_W-1:0]  len_q   [MAX_BLOCKS];
	logic [PURGE_W-1:0] purge_q [MAX_BLOCKS];
	logic               lock_q  [MAX_BLOCKS];
	logic [LINK_W-1:0]  link_q  [MAX_BLOCKS];
	logic [OWNER_W-1:0] blk_owner_q [MAX_BLOCKS];

	logic [LINK_W-1:0]  flh_q, rover_q, scan_q, last_q, p_q, nw_q, stop_q, sstart_q;
	logic [ADDR_W-1:0]  seg_q, pos_q;
	logic [1:0]         pass_q;
	logic [STEP_W-1:0]  steps_q;

	logic [CMD_W-1:0]   cmd_q;
	logic [OWNER_W-1:0] own_q, fown_q;
	logic [ADDR_W-1:0]  size_q;
	logic [PURGE_W-1:0] purge_lv_q;
	logic               lock_f_q;

	logic               out_v_q, last_o_q;
	logic [KIND_W-1:0]  kind_q;
	logic [OWNER_W-1:0] rowner_q;
	logic [ADDR_W-1:0]  addr_q, src_q, mlen_q;
	logic [STAT_W-1:0]  stat_q;

	logic [LINK_W-1:0]  ra;
	logic [IDX_W-1:0]   ri;
	logic               r_valid, r_big, r_lock;
	logic [ADDR_W-1:0]  r_start, r_len, r_end, gap;
	logic [PURGE_W-1:0] r_purge;
	logic [OWNER_W-1:0] r_owner;
	logic [LINK_W-1:0]  r_link, rover_or_head;
	logic               f_found, c_evict, ap_found, a_stop, a_fit, ev_done;
	logic               s_found, s_fail, emit_ok;
	logic [ADDR_W-1:0]  new_base, new_limit;

	logic               em, em_last;
	logic [KIND_W-1:0]  em_kind;
	logic [OWNER_W-1:0] em_owner;
	logic [ADDR_W-1:0]  em_addr, em_src, em_len;
	logic [STAT_W-1:0]  em_stat;

	always_comb begin
		case (dcmd.op)
			OP_F_ROVER: ra = rover_q;
			OP_F_HEAD, OP_C_HEAD, OP_AP_HEAD: ra = '0;
			OP_A_SET: ra = last_q;
			OP_A_RES: ra = flh_q;
			OP_A_EV: ra = p_q;
			default: ra = scan_q;
		endcase
	end

	assign ri       = ra[IDX_W-1:0];
	assign r_valid  = is_valid(ra);
	assign r_big    = ra >= LINK_W'(2);
	assign r_start  = start_q[ri];
	assign r_len    = len_q[ri];
	assign r_purge  = purge_q[ri];
	assign r_lock   = lock_q[ri];
	assign r_owner  = blk_owner_q[ri];
	assign r_link   = link_q[ri];
	assign r_end    = r_start + r_len;
	assign gap      = r_start - seg_q;
	assign rover_or_head = is_valid(rover_q) ? rover_q : '0;

	assign f_found  = r_valid && r_big && (r_owner == fown_q);
	assign c_evict  = r_valid && !r_lock && (r_purge != '0) && is_valid(last_q);
	assign ap_found = r_valid && !r_lock && (r_purge != '0) && r_big;
	assign a_stop   = (scan_q == stop_q) || !r_valid;
	assign a_fit    = gap >= size_q;
	assign ev_done  = (p_q == scan_q) || !r_valid;
	assign s_found  = r_valid && r_big && (r_owner == own_q);
	assign s_fail   = !s_found && ((is_valid(r_link) && r_link == sstart_q) ||
		steps_q == SET_STEP_LAST);
	assign emit_ok  = !out_v_q || out_ready;

	assign new_base  = (cfg_index == REG_BASE) ? cfg_data : base_q;
	assign new_limit = (cfg_index == REG_BASE) ? limit_q : cfg_data;

	always_comb begin
		dstat.cmd        = cmd_q;
		dstat.flh_valid  = is_valid(flh_q);
		dstat.rover_zero = rover_q == '0;
		dstat.pass       = pass_q;
		dstat.f_found    = f_found;
		dstat.f_end      = !r_valid;
		dstat.c_end      = !r_valid;
		dstat.c_evict    = c_evict;
		dstat.ap_end     = !r_valid;
		dstat.ap_found   = ap_found;
		dstat.a_stop     = a_stop;
		dstat.a_fit      = a_fit;
		dstat.ev_done    = ev_done;
		dstat.s_done     = s_found || s_fail;
		dstat.emit_ok    = emit_ok;
	end

	always_comb begin
		em       = 1'b0;
		em_last  = 1'b0;
		em_kind  = KIND_DONE;
		em_owner = own_q;
		em_addr  = '0;
		em_src   = '0;
		em_len   = '0;
		em_stat  = ST_OK;
		case (dcmd.op)
			OP_C_SCAN: begin
				if (c_evict) begin
					em       = 1'b1;
					em_kind  = KIND_PURGED;
					em_owner = r_owner;
				end else if (r_valid && !r_lock && r_start != pos_q) begin
					em       = 1'b1;
					em_kind  = KIND_MOVE;
					em_owner = r_owner;
					em_addr  = pos_q;
					em_src   = r_start;
					em_len   = r_len;
				end
			end
			OP_AP_SCAN: begin
				if (ap_found) begin
					em       = 1'b1;
					em_kind  = KIND_PURGED;
					em_owner = r_owner;
				end
			end
			OP_A_EV: begin
				em = 1'b1;
				if (ev_done) begin
					em_kind = KIND_GRANT;
					em_addr = seg_q;
					em_last = 1'b1;
				end else begin
					em_kind  = KIND_PURGED;
					em_owner = r_owner;
				end
			end
			OP_S_SCAN: begin
				if (s_found) begin
					em      = 1'b1;
					em_last = 1'b1;
				end else if (s_fail) begin
					em      = 1'b1;
					em_last = 1'b1;
					em_kind = KIND_ERROR;
					em_stat = ST_NOT_FOUND;
				end
			end
			OP_FIN: begin
				em      = 1'b1;
				em_last = 1'b1;
				em_kind = dcmd.fin_kind;
				em_stat = dcmd.fin_status;
			end
			default: em = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= '0;
			limit_q  <= LIMIT_RESET;
			for (int i = 0; i < MAX_BLOCKS; i++) begin
				start_q[i] <= '0;
				len_q[i]   <= '0;
				purge_q[i] <= '0;
				lock_q[i]  <= (i < 2);
				link_q[i]  <= init_link(i);
			end
			start_q[1] <= LIMIT_RESET;
			flh_q    <= LINK_W'(2);
			rover_q  <= '0;
			scan_q   <= '0;
			last_q   <= '0;
			p_q      <= '0;
			nw_q     <= '0;
			stop_q   <= NIL_LINK;
			sstart_q <= '0;
			pass_q   <= '0;
			steps_q  <= '0;
			out_v_q  <= 1'b0;
		end else begin
			if (em)
				out_v_q <= 1'b1;
			else if (out_ready)
				out_v_q <= 1'b0;
			case (dcmd.op)
				OP_CFG: begin
					base_q  <= new_base;
					limit_q <= new_limit;
					for (int i = 0; i < MAX_BLOCKS; i++) begin
						start_q[i] <= '0;
						len_q[i]   <= '0;
						purge_q[i] <= '0;
						lock_q[i]  <= (i < 2);
						link_q[i]  <= init_link(i);
					end
					start_q[0] <= new_base;
					start_q[1] <= new_limit;
					flh_q      <= LINK_W'(2);
					rover_q    <= '0;
				end
				OP_F_ROVER: begin
					if (f_found)
						rover_q <= '0;
				end
				OP_F_HEAD: begin
					scan_q <= r_link;
					last_q <= '0;
				end
				OP_F_SCAN: begin
					if (f_found) begin
						p_q <= r_link;
					end else if (r_valid) begin
						last_q <= scan_q;
						scan_q <= r_link;
					end
				end
				OP_UNLINK: link_q[last_q[IDX_W-1:0]] <= p_q;
				OP_RELSCAN: begin
					link_q[scan_q[IDX_W-1:0]] <= flh_q;
					flh_q  <= scan_q;
					scan_q <= p_q;
				end
				OP_C_HEAD: begin
					scan_q <= '0;
					last_q <= NIL_LINK;
				end
				OP_C_SCAN: begin
					if (!r_valid) begin
						rover_q <= '0;
					end else if (r_lock) begin
						last_q <= scan_q;
						scan_q <= r_link;
					end else if (c_evict) begin
						p_q <= r_link;
					end else begin
						if (r_start != pos_q)
							start_q[ri] <= pos_q;
						last_q <= scan_q;
						scan_q <= r_link;
					end
				end
				OP_AP_HEAD: scan_q <= r_link;
				OP_AP_SCAN: begin
					if (r_valid && !ap_found)
						scan_q <= r_link;
				end
				OP_A_RES: begin
					nw_q   <= flh_q;
					flh_q  <= r_link;
					pass_q <= '0;
				end
				OP_A_PASS: begin
					case (pass_q)
						2'd0: begin
							last_q <= rover_or_head;
							stop_q <= NIL_LINK;
						end
						2'd1: begin
							if (rover_q == '0) begin
								pass_q <= 2'd2;
							end else begin
								last_q <= '0;
								stop_q <= rover_q;
							end
						end
						default: pass_q <= pass_q;
					endcase
				end
				OP_A_P2: begin
					last_q <= '0;
					stop_q <= NIL_LINK;
				end
				OP_A_SET: begin
					scan_q <= r_link;
					p_q    <= r_link;
				end
				OP_A_SCAN: begin
					if (a_stop) begin
						pass_q <= pass_q + 2'd1;
					end else if (!a_fit) begin
						if (r_lock || r_purge == '0) begin
							last_q <= scan_q;
							p_q    <= r_link;
						end
						scan_q <= r_link;
					end
				end
				OP_A_FIT1: begin
					link_q[last_q[IDX_W-1:0]]  <= nw_q;
					start_q[nw_q[IDX_W-1:0]]   <= seg_q;
					len_q[nw_q[IDX_W-1:0]]     <= size_q;
					purge_q[nw_q[IDX_W-1:0]]   <= '0;
					lock_q[nw_q[IDX_W-1:0]]    <= 1'b0;
				end
				OP_A_FIT2: link_q[nw_q[IDX_W-1:0]] <= scan_q;
				OP_A_EV: begin
					if (ev_done) begin
						rover_q <= nw_q;
					end else begin
						link_q[ri] <= flh_q;
						flh_q      <= p_q;
						p_q        <= r_link;
					end
				end
				OP_A_FAIL: begin
					link_q[nw_q[IDX_W-1:0]] <= flh_q;
					flh_q <= nw_q;
				end
				OP_S_INIT: begin
					sstart_q <= rover_or_head;
					scan_q   <= rover_or_head;
					steps_q  <= '0;
				end
				OP_S_SCAN: begin
					if (s_found) begin
						rover_q <= scan_q;
						if (cmd_q == CMD_SET_LOCK)
							lock_q[ri] <= lock_f_q;
						else
							purge_q[ri] <= purge_lv_q;
					end else if (s_fail) begin
						rover_q <= sstart_q;
					end else begin
						scan_q  <= is_valid(r_link) ? r_link : '0;
						steps_q <= steps_q + STEP_W'(1);
					end
				end
				default: pass_q <= pass_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (em) begin
			kind_q   <= em_kind;
			rowner_q <= em_owner;
			addr_q   <= em_addr;
			src_q    <= em_src;
			mlen_q   <= em_len;
			stat_q   <= em_stat;
			last_o_q <= em_last;
		end
		case (dcmd.op)
			OP_LOAD: begin
				cmd_q      <= cmd;
				own_q      <= owner_id;
				fown_q     <= owner_id;
				size_q     <= request_size;
				purge_lv_q <= purge_level;
				lock_f_q   <= lock_flag;
			end
			OP_C_HEAD: pos_q <= r_start;
			OP_C_SCAN: begin
				if (r_valid && r_lock)
					pos_q <= r_end;
				else if (r_valid && !c_evict)
					pos_q <= pos_q + r_len;
			end
			OP_AP_SCAN: begin
				if (ap_found)
					fown_q <= r_owner;
			end
			OP_A_SET: seg_q <= r_end;
			OP_A_SCAN: begin
				if (!a_stop && !a_fit && (r_lock || r_purge == '0))
					seg_q <= r_end;
			end
			OP_A_FIT1: blk_owner_q[nw_q[IDX_W-1:0]] <= own_q;
			default: seg_q <= seg_q;
		endcase
	end

	assign out_valid      = out_v_q;
	assign kind           = kind_q;
	assign result_owner   = rowner_q;
	assign address        = addr_q;
	assign source_address = src_q;
	assign move_length    = mlen_q;
	assign status         = stat_q;
	assign last           = last_o_q;

endmodule

>>> design/psa_ctrl.sv
// Controller of the purgeable segment allocator: one-hot state machine
// that sequences free, compact, allocate and set walks over the datapath.
// Depends on psa_pkg; drives psa_dpath through dp_cmd_t.
module psa_ctrl import psa_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  logic     cfg_valid,
	output logic     cfg_ready,
	input  dp_stat_t dstat,
	output dp_cmd_t  dcmd
);

	typedef enum logic [29:0] {
		S_IDLE  = 30'h0000_0001,
		S_DISP  = 30'h0000_0002,
		S_F0    = 30'h0000_0004,
		S_F1    = 30'h0000_0008,
		S_F2    = 30'h0000_0010,
		S_F3    = 30'h0000_0020,
		S_F4    = 30'h0000_0040,
		S_DONE  = 30'h0000_0080,
		S_ERR1  = 30'h0000_0100,
		S_ERR2  = 30'h0000_0200,
		S_ERR3  = 30'h0000_0400,
		S_C0    = 30'h0000_0800,
		S_C1    = 30'h0000_1000,
		S_C2    = 30'h0000_2000,
		S_C3    = 30'h0000_4000,
		S_A0    = 30'h0000_8000,
		S_AP0   = 30'h0001_0000,
		S_AP1   = 30'h0002_0000,
		S_AP2   = 30'h0004_0000,
		S_ARES  = 30'h0008_0000,
		S_APASS = 30'h0010_0000,
		S_AP2B  = 30'h0020_0000,
		S_ASET  = 30'h0040_0000,
		S_ALOOP = 30'h0080_0000,
		S_AFIT1 = 30'h0100_0000,
		S_AFIT2 = 30'h0200_0000,
		S_AEV   = 30'h0400_0000,
		S_AFAIL = 30'h0800_0000,
		S_SINIT = 30'h1000_0000,
		S_SLOOP = 30'h2000_0000
	} state_t;

	state_t state_q, state_d;
	logic   fret_q, fret_d, cret_q, cret_d;

	always_comb begin
		state_d         = state_q;
		fret_d          = fret_q;
		cret_d          = cret_q;
		dcmd.op         = OP_NOP;
		dcmd.fin_kind   = KIND_DONE;
		dcmd.fin_status = ST_OK;
		in_ready        = 1'b0;
		cfg_ready       = 1'b0;
		case (state_q)
			S_IDLE: begin
				cfg_ready = 1'b1;
				in_ready  = !cfg_valid;
				if (cfg_valid) begin
					dcmd.op = OP_CFG;
				end else if (in_valid) begin
					dcmd.op = OP_LOAD;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				case (dstat.cmd)
					CMD_ALLOC: state_d = S_A0;
					CMD_FREE: begin
						fret_d  = 1'b0;
						state_d = S_F0;
					end
					CMD_SET_PURGE, CMD_SET_LOCK: state_d = S_SINIT;
					CMD_COMPACT: begin
						cret_d  = 1'b0;
						state_d = S_C0;
					end
					default: state_d = S_DONE;
				endcase
			end
			S_F0: begin
				dcmd.op = OP_F_ROVER;
				state_d = S_F1;
			end
			S_F1: begin
				dcmd.op = OP_F_HEAD;
				state_d = S_F2;
			end
			S_F2: begin
				dcmd.op = OP_F_SCAN;
				if (dstat.f_found)
					state_d = S_F3;
				else if (dstat.f_end)
					state_d = fret_q ? S_AP2 : S_ERR2;
			end
			S_F3: begin
				dcmd.op = OP_UNLINK;
				state_d = S_F4;
			end
			S_F4: begin
				dcmd.op = OP_RELSCAN;
				state_d = fret_q ? S_AP2 : S_DONE;
			end
			S_DONE, S_ERR1, S_ERR2, S_ERR3: begin
				if (dstat.emit_ok) begin
					dcmd.op = OP_FIN;
					state_d = S_IDLE;
				end
				if (state_q != S_DONE)
					dcmd.fin_kind = KIND_ERROR;
				if (state_q == S_ERR1)
					dcmd.fin_status = ST_NO_MEMORY;
				else if (state_q == S_ERR2)
					dcmd.fin_status = ST_NOT_FOUND;
				else if (state_q == S_ERR3)
					dcmd.fin_status = ST_NO_PURGE;
			end
			S_C0: begin
				dcmd.op = OP_C_HEAD;
				state_d = S_C1;
			end
			S_C1: begin
				if (dstat.emit_ok) begin
					dcmd.op = OP_C_SCAN;
					if (dstat.c_end)
						state_d = cret_q ? S_AP2B : S_DONE;
					else if (dstat.c_evict)
						state_d = S_C2;
				end
			end
			S_C2: begin
				dcmd.op = OP_UNLINK;
				state_d = S_C3;
			end
			S_C3: begin
				dcmd.op = OP_RELSCAN;
				state_d = S_C1;
			end
			S_A0: state_d = dstat.flh_valid ? S_ARES : S_AP0;
			S_AP0: begin
				dcmd.op = OP_AP_HEAD;
				state_d = S_AP1;
			end
			S_AP1: begin
				if (dstat.emit_ok) begin
					dcmd.op = OP_AP_SCAN;
					if (dstat.ap_end) begin
						state_d = S_ERR3;
					end else if (dstat.ap_found) begin
						fret_d  = 1'b1;
						state_d = S_F0;
					end
				end
			end
			S_AP2: state_d = dstat.flh_valid ? S_ARES : S_ERR3;
			S_ARES: begin
				dcmd.op = OP_A_RES;
				state_d = S_APASS;
			end
			S_APASS: begin
				dcmd.op = OP_A_PASS;
				case (dstat.pass)
					2'd0: state_d = S_ASET;
					2'd1: begin
						if (!dstat.rover_zero)
							state_d = S_ASET;
					end
					2'd2: begin
						cret_d  = 1'b1;
						state_d = S_C0;
					end
					default: state_d = S_AFAIL;
				endcase
			end
			S_AP2B: begin
				dcmd.op = OP_A_P2;
				state_d = S_ASET;
			end
			S_ASET: begin
				dcmd.op = OP_A_SET;
				state_d = S_ALOOP;
			end
			S_ALOOP: begin
				dcmd.op = OP_A_SCAN;
				if (dstat.a_stop)
					state_d = S_APASS;
				else if (dstat.a_fit)
					state_d = S_AFIT1;
			end
			S_AFIT1: begin
				dcmd.op = OP_A_FIT1;
				state_d = S_AFIT2;
			end
			S_AFIT2: begin
				dcmd.op = OP_A_FIT2;
				state_d = S_AEV;
			end
			S_AEV: begin
				if (dstat.emit_ok) begin
					dcmd.op = OP_A_EV;
					if (dstat.ev_done)
						state_d = S_IDLE;
				end
			end
			S_AFAIL: begin
				dcmd.op = OP_A_FAIL;
				state_d = S_ERR1;
			end
			S_SINIT: begin
				dcmd.op = OP_S_INIT;
				state_d = S_SLOOP;
			end
			S_SLOOP: begin
				if (dstat.emit_ok) begin
					dcmd.op = OP_S_SCAN;
					if (dstat.s_done)
						state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fret_q  <= 1'b0;
			cret_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			fret_q  <= fret_d;
			cret_q  <= cret_d;
		end
	end

endmodule

>>> design/purgeable_segment_allocator_core.sv
// Top level of the purgeable segment allocator: controller plus datapath.
// Depends on psa_pkg, psa_ctrl and psa_dpath.
//
// Usage: commands enter on the in channel (in_valid/in_ready) as one word
// of cmd, owner_id, request_size, purge_level and lock_flag. Each command
// yields one or more result words on the out channel (out_valid/out_ready);
// the final word of a command carries last = 1. heap_base and heap_limit
// are written on the cfg channel (cfg_index 0 base, 1 limit) while idle;
// either write rebuilds the descriptor pool.
// Free walks the list once, set walks it from the rover with wrap,
// compact once, and allocate up to three passes plus a compaction;
// all walks share the single descriptor read port.
// The next command is taken once the final word is in the output register.
// When the receiver stalls, the walk holds at the next result until the
// output register frees. Reset empties the heap to its two sentinels at
// base 0 and limit 0xFFFFFF and clears the output valid flag.
module purgeable_segment_allocator_core import psa_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [CMD_W-1:0]     cmd,
	input  logic [OWNER_W-1:0]   owner_id,
	input  logic [ADDR_W-1:0]    request_size,
	input  logic [PURGE_W-1:0]   purge_level,
	input  logic                 lock_flag,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [ADDR_W-1:0]    cfg_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [KIND_W-1:0]    kind,
	output logic [OWNER_W-1:0]   result_owner,
	output logic [ADDR_W-1:0]    address,
	output logic [ADDR_W-1:0]    source_address,
	output logic [ADDR_W-1:0]    move_length,
	output logic [STAT_W-1:0]    status,
	output logic                 last
);

	dp_cmd_t  dcmd;
	dp_stat_t dstat;

	psa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.dstat     (dstat),
		.dcmd      (dcmd)
	);

	psa_dpath u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.dcmd           (dcmd),
		.dstat          (dstat),
		.cmd            (cmd),
		.owner_id       (owner_id),
		.request_size   (request_size),
		.purge_level    (purge_level),
		.lock_flag      (lock_flag),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.kind           (kind),
		.result_owner   (result_owner),
		.address        (address),
		.source_address (source_address),
		.move_length    (move_length),
		.status         (status),
		.last           (last)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("command accepted while previous still running");

	a_cfg_excl: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |-> !(in_valid && in_ready))
		else $error("config write and command accepted together");

	a_mid_word_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> !in_ready)
		else $error("idle while a command's result word is not final");

endmodule
